[src/audio_interval_rechunk_queue_macros.svh]
// ---------------------------------------------------------------------------
// audio_interval_rechunk_queue macros
// concurrent assertion shorthands, sampled on clk_i, off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef AUDIO_INTERVAL_RECHUNK_QUEUE_MACROS_SVH
`define AUDIO_INTERVAL_RECHUNK_QUEUE_MACROS_SVH

// consequent must hold in the same cycle
`define AIRQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("airq assertion failed");

// consequent must hold in the following cycle
`define AIRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("airq assertion failed");

`endif

[src/airq_pkg.sv]
// ---------------------------------------------------------------------------
// airq_pkg
// shared types and sizes of the audio interval rechunk queue
// ---------------------------------------------------------------------------
`default_nettype none

package airq_pkg;

  // queue geometry and internal counter width
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;

  // fixed field widths
  localparam int TIME_W   = 48;
  localparam int RATE_W   = 20;
  localparam int TL_W     = 16;
  localparam int TAG_W    = 16;
  localparam int REQ_W    = 31;
  localparam int QUEUED_W = 47;
  localparam int FCOUNT_W = 5;
  localparam int STATUS_W = 4;
  localparam int OP_W     = 3;

  // derived sizes
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QT_W   = TIME_BITS - 1;
  localparam int CMP_W  = (QT_W > TIME_W) ? QT_W : TIME_W;
  localparam int RQC_W  = (QT_W > REQ_W) ? QT_W : REQ_W;

  // operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_TAKE   = 3'd1,
    OP_FINISH = 3'd2,
    OP_SETTLE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_TERMINAL    = 4'd1,
    ST_INVALID     = 4'd2,
    ST_DISCONT     = 4'd3,
    ST_OVERFLOW    = 4'd4,
    ST_BAD_TAKE    = 4'd5,
    ST_RESIDUE     = 4'd6,
    ST_SETTLE_MISS = 4'd7,
    ST_FULL        = 4'd8
  } status_e;

  // input word
  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [TIME_W-1:0] frag_begin;
    logic signed [TIME_W-1:0] frag_end;
    logic [RATE_W-1:0]        frag_rate;
    logic [TL_W-1:0]          timeline_id;
    logic                     frag_valid;
    logic [TAG_W-1:0]         frag_tag;
    logic [REQ_W-1:0]         request_count;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     piece_present;
    logic signed [TIME_W-1:0] piece_begin;
    logic signed [TIME_W-1:0] piece_end;
    logic [TAG_W-1:0]         piece_tag;
    logic                     last;
    logic [QUEUED_W-1:0]      queued_samples;
    logic [FCOUNT_W-1:0]      fragment_count;
  } out_word_t;

  // one queued fragment
  typedef struct packed {
    logic [TIME_W-1:0] ent_begin;
    logic [TIME_W-1:0] ent_end;
    logic [TAG_W-1:0]  ent_tag;
  } entry_t;

endpackage

`default_nettype wire

[src/audio_interval_rechunk_queue.sv]
// ---------------------------------------------------------------------------
// audio_interval_rechunk_queue
// FIFO of sample intervals that re-chunks queued audio into requested sizes
// ---------------------------------------------------------------------------
// Push, finish, settle and clear each return one result word the cycle after
// the input word is taken, so they run at one word per cycle while the output
// keeps draining. A take that is not rejected returns one piece per fragment
// it touches. The queue is first scanned from the head, one read (S_SCAN_RD)
// and one compare (S_SCAN) per fragment, to learn how many fragments are left
// after the take. Every piece word carries the sample and fragment counts as
// they stand after the whole take. Each fragment is then read again from the
// fragment memory, which has one write port and one registered read port, in
// S_READ, then trimmed and written back in S_CALC. A stalled result word holds
// the walk. No new input word is taken while a take is walking the queue.
// Fragment entries are only ever read while they hold queued data.
`default_nettype none

module audio_interval_rechunk_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  airq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output airq_pkg::out_word_t out_word_o
);
  import airq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_READ,
    S_CALC
  } state_e;

  localparam logic [QT_W-1:0] COUNT_MAX = '1;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [TL_W-1:0]     held_tl_q, held_tl_d;
  logic [RATE_W-1:0]   held_rate_q, held_rate_d;
  logic [TIME_W-1:0]   exp_begin_q, exp_begin_d;
  logic [QT_W-1:0]     total_q, total_d;
  logic                started_q, started_d;
  logic                failed_q, failed_d;
  logic [REQ_W-1:0]    remain_q, remain_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_word_q, out_word_d;

  // scan ahead of a take
  logic [PTR_W-1:0]    scan_ptr_q, scan_ptr_d;
  logic [REQ_W-1:0]    scan_rem_q, scan_rem_d;
  logic [CNT_W-1:0]    fin_cnt_q, fin_cnt_d;

  // fragment memory
  entry_t              mem_q [QUEUE_DEPTH];
  entry_t              rd_q;
  logic                mem_we, mem_re;
  logic [PTR_W-1:0]    mem_waddr, mem_raddr;
  entry_t              mem_wdata;

  // result staging
  logic                res_load;
  status_e             res_status;
  logic                res_piece;
  logic [TIME_W-1:0]   res_begin, res_end;
  logic [TAG_W-1:0]    res_tag;
  logic                res_last;

  logic                out_free, accept;

  // push checks
  logic                push_ordered, push_mismatch, push_over, push_full;
  logic [TIME_W-1:0]   push_added;
  logic [CMP_W-1:0]    push_room;

  // request checks
  logic [RQC_W-1:0]    req_wide, total_wide;

  // take datapath
  logic [TIME_W-1:0]   take_avail, take_new_begin;
  logic                take_whole;
  logic [REQ_W-1:0]    take_used;
  logic                scan_whole;
  logic [REQ_W-1:0]    scan_rem_next;
  logic [QT_W-1:0]     take_final_total;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // push validity, continuity and capacity
  assign push_ordered  = in_word_i.frag_end > in_word_i.frag_begin;
  assign push_added    = TIME_W'(in_word_i.frag_end - in_word_i.frag_begin);
  assign push_room     = CMP_W'(COUNT_MAX) - CMP_W'(total_q);
  assign push_over     = CMP_W'(push_added) > push_room;
  assign push_full     = count_q >= CNT_W'(QUEUE_DEPTH);
  assign push_mismatch = started_q &&
                         ((in_word_i.timeline_id != held_tl_q) ||
                          (in_word_i.frag_rate != held_rate_q) ||
                          (TIME_W'(in_word_i.frag_begin) != exp_begin_q));

  assign req_wide   = RQC_W'(in_word_i.request_count);
  assign total_wide = RQC_W'(total_q);

  // trim the head fragment against what is still owed
  assign take_avail     = rd_q.ent_end - rd_q.ent_begin;
  assign take_whole     = take_avail <= TIME_W'(remain_q);
  assign take_used      = take_whole ? REQ_W'(take_avail) : remain_q;
  assign take_new_begin = rd_q.ent_begin + TIME_W'(take_used);

  // scan counts the fragments a take will use up
  assign scan_whole    = take_avail <= TIME_W'(scan_rem_q);
  assign scan_rem_next = scan_rem_q - REQ_W'(take_avail);

  // samples left once the take is done, fixed during the walk
  assign take_final_total = total_q - QT_W'(remain_q);

  // control and next-state logic
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    held_tl_d   = held_tl_q;
    held_rate_d = held_rate_q;
    exp_begin_d = exp_begin_q;
    total_d     = total_q;
    started_d   = started_q;
    failed_d    = failed_q;
    remain_d    = remain_q;
    scan_ptr_d  = scan_ptr_q;
    scan_rem_d  = scan_rem_q;
    fin_cnt_d   = fin_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;

    mem_we    = 1'b0;
    mem_waddr = tail_q;
    mem_wdata = '{ent_begin: TIME_W'(in_word_i.frag_begin),
                  ent_end:   TIME_W'(in_word_i.frag_end),
                  ent_tag:   in_word_i.frag_tag};
    mem_re    = 1'b0;
    mem_raddr = head_q;

    res_load   = 1'b0;
    res_status = ST_OK;
    res_piece  = 1'b0;
    res_begin  = '0;
    res_end    = '0;
    res_tag    = '0;
    res_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (op_e'(in_word_i.opcode))
            OP_PUSH: begin
              if (failed_q) begin
                res_status = ST_TERMINAL;
              end else if (!in_word_i.frag_valid || !push_ordered) begin
                failed_d   = 1'b1;
                res_status = ST_INVALID;
              end else begin
                if (!started_q) begin
                  held_tl_d   = in_word_i.timeline_id;
                  held_rate_d = in_word_i.frag_rate;
                  started_d   = 1'b1;
                end
                if (push_mismatch) begin
                  failed_d   = 1'b1;
                  res_status = ST_DISCONT;
                end else if (push_over) begin
                  failed_d   = 1'b1;
                  res_status = ST_OVERFLOW;
                end else if (push_full) begin
                  failed_d   = 1'b1;
                  res_status = ST_FULL;
                end else begin
                  mem_we      = 1'b1;
                  tail_d      = ptr_next(tail_q);
                  count_d     = count_q + 1'b1;
                  total_d     = total_q + QT_W'(push_added);
                  exp_begin_d = TIME_W'(in_word_i.frag_end);
                end
              end
            end
            OP_TAKE: begin
              if (failed_q) begin
                res_status = ST_TERMINAL;
              end else if ((in_word_i.request_count == '0) || (req_wide > total_wide)) begin
                failed_d   = 1'b1;
                res_status = ST_BAD_TAKE;
              end else begin
                // pieces come from the walk, no result yet
                res_load   = 1'b0;
                remain_d   = in_word_i.request_count;
                scan_rem_d = in_word_i.request_count;
                scan_ptr_d = head_q;
                fin_cnt_d  = count_q;
                state_d    = S_SCAN_RD;
              end
            end
            OP_FINISH: begin
              if (failed_q) begin
                res_status = ST_TERMINAL;
              end else if ((total_q != '0) || (count_q != '0)) begin
                res_status = ST_RESIDUE;
              end
            end
            OP_SETTLE: begin
              if (req_wide != total_wide) begin
                failed_d   = 1'b1;
                res_status = ST_SETTLE_MISS;
              end else if (failed_q) begin
                res_status = ST_TERMINAL;
              end else begin
                head_d  = tail_q;
                count_d = '0;
                total_d = '0;
              end
            end
            OP_CLEAR: begin
              head_d      = '0;
              tail_d      = '0;
              count_d     = '0;
              held_tl_d   = '0;
              held_rate_d = '0;
              exp_begin_d = '0;
              total_d     = '0;
              started_d   = 1'b0;
              failed_d    = 1'b0;
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = scan_ptr_q;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (scan_whole) begin
          fin_cnt_d  = fin_cnt_q - 1'b1;
          scan_rem_d = scan_rem_next;
          scan_ptr_d = ptr_next(scan_ptr_q);
        end
        state_d = (scan_whole && (scan_rem_next != '0)) ? S_SCAN_RD : S_READ;
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = head_q;
          mem_wdata = '{ent_begin: take_new_begin,
                        ent_end:   rd_q.ent_end,
                        ent_tag:   rd_q.ent_tag};
          remain_d  = remain_q - take_used;
          total_d   = total_q - QT_W'(take_used);
          if (take_whole) begin
            head_d  = ptr_next(head_q);
            count_d = count_q - 1'b1;
          end
          res_load   = 1'b1;
          res_piece  = 1'b1;
          res_begin  = rd_q.ent_begin;
          res_end    = take_new_begin;
          res_tag    = rd_q.ent_tag;
          res_last   = (remain_d == '0);
          state_d    = res_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // result word reflects the state after the whole step
    if (res_load) begin
      out_valid_d               = 1'b1;
      out_word_d.status         = res_status;
      out_word_d.piece_present  = res_piece;
      out_word_d.piece_begin    = res_begin;
      out_word_d.piece_end      = res_end;
      out_word_d.piece_tag      = res_tag;
      out_word_d.last           = res_last;
      out_word_d.queued_samples = res_piece ? QUEUED_W'(take_final_total)
                                            : QUEUED_W'(total_d);
      out_word_d.fragment_count = res_piece ? FCOUNT_W'(fin_cnt_q)
                                            : FCOUNT_W'(count_d);
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      held_tl_q   <= '0;
      held_rate_q <= '0;
      exp_begin_q <= '0;
      total_q     <= '0;
      started_q   <= 1'b0;
      failed_q    <= 1'b0;
      remain_q    <= '0;
      scan_ptr_q  <= '0;
      scan_rem_q  <= '0;
      fin_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      held_tl_q   <= held_tl_d;
      held_rate_q <= held_rate_d;
      exp_begin_q <= exp_begin_d;
      total_q     <= total_d;
      started_q   <= started_d;
      failed_q    <= failed_d;
      remain_q    <= remain_d;
      scan_ptr_q  <= scan_ptr_d;
      scan_rem_q  <= scan_rem_d;
      fin_cnt_q   <= fin_cnt_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  // fragment memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

endmodule

`default_nettype wire

[src/airq_checker.sv]
// ---------------------------------------------------------------------------
// airq_checker
// port-level checks on the result channel of the rechunk queue
// ---------------------------------------------------------------------------
`default_nettype none

`include "audio_interval_rechunk_queue_macros.svh"

module airq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input airq_pkg::out_word_t out_word_i
);
  import airq_pkg::*;

  logic out_stall, piece_good;

  assign out_stall  = out_valid_i && !out_ready_i;
  assign piece_good = (out_word_i.status == ST_OK) &&
                      (out_word_i.piece_end > out_word_i.piece_begin);

  // a stalled result word stays put
  `AIRQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(out_word_i))

  // no new input word while a result is stuck
  `AIRQ_ASSERT_NOW(a_no_take_on_stall, out_stall, !in_ready_i)

  // pieces are non-empty and always come with ok status
  `AIRQ_ASSERT_NOW(a_piece_ok, out_valid_i && out_word_i.piece_present, piece_good)

  // a word without a piece closes its step
  `AIRQ_ASSERT_NOW(a_plain_last, out_valid_i && !out_word_i.piece_present, out_word_i.last)

endmodule

bind audio_interval_rechunk_queue airq_checker u_airq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);

`default_nettype wire
